// File: rtl/scanline_edge_pd_steering_defines.svh
// ----------------------------------------------------------------------------
// Scanline edge PD steering - assertion macros
// Shared concurrent assertion helpers. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef SCANLINE_EDGE_PD_STEERING_DEFINES_SVH
`define SCANLINE_EDGE_PD_STEERING_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every edge out of reset
`define SEPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define SEPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define SEPD_ASSERT(lbl, prop, msg)
`define SEPD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/sepd_pkg.sv
// ----------------------------------------------------------------------------
// Scanline edge PD steering - package
// Field widths, register indexes, reset values and the beat types shared
// between the scan stage and the steering stage.
// ----------------------------------------------------------------------------
package sepd_pkg;

  // field widths
  localparam int PIX_W   = 8;
  localparam int COL_W   = 9;
  localparam int SW_W    = 7;
  localparam int THR_W   = 8;
  localparam int ROAD_W  = 8;
  localparam int GAIN_W  = 12;
  localparam int SPD_W   = 8;
  localparam int STEER_W = 19;

  // internal arithmetic widths (cover image widths up to 512)
  localparam int WIN_W  = 12;  // signed window bounds
  localparam int ERR_W  = 10;  // signed lane error
  localparam int DERR_W = 11;  // signed error delta
  localparam int PROD_W = 24;  // signed gain products
  localparam int SUM_W  = 25;  // signed PD sum

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROAD_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LANE_SIDE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd6;

  // register reset values
  localparam logic [SW_W-1:0]   WIN_WIDTH_RST   = 7'd40;
  localparam logic [THR_W-1:0]  EDGE_THR_RST    = 8'd50;
  localparam logic [ROAD_W-1:0] ROAD_WIDTH_RST  = 8'd80;
  localparam logic              LANE_SIDE_RST   = 1'b1;
  localparam logic [GAIN_W-1:0] KP_GAIN_RST     = 12'd640;
  localparam logic [GAIN_W-1:0] KD_GAIN_RST     = 12'd51;
  localparam logic [SPD_W-1:0]  SPEED_LIMIT_RST = 8'd20;

  // state reset values
  localparam int              HALF_ROAD_RST = 40;
  localparam logic [SPD_W-1:0] ROW_CNT_RST  = 8'd10;
  localparam logic [SPD_W-1:0] ROW_CNT_MAX  = 8'd255;

  // steering saturation bounds
  localparam logic signed [SUM_W-1:0] STEER_MAX = 25'sd262143;
  localparam logic signed [SUM_W-1:0] STEER_MIN = -25'sd262144;

  typedef struct packed {
    logic [SW_W-1:0]   win_width;
    logic [THR_W-1:0]  edge_thresh;
    logic [ROAD_W-1:0] road_width;
    logic              lane_side;
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] kd_gain;
    logic [SPD_W-1:0]  speed_limit;
  } cfg_t;

  // row-end beat handed from the scan stage to the steering stage
  typedef struct packed {
    logic                     found;
    logic [COL_W-1:0]         edge_col;
    logic [COL_W-1:0]         track_col;
    logic signed [ERR_W-1:0]  err;
    logic signed [DERR_W-1:0] derr;
    logic [SPD_W-1:0]         speed;
  } row_res_t;

endpackage

// File: rtl/sepd_scan.sv
// ----------------------------------------------------------------------------
// Scanline edge PD steering - row scan stage
// Input register, windowed edge search over the pixel stream, tracked column,
// lane error and speed ramp. Emits one registered beat per row end.
// ----------------------------------------------------------------------------
`include "scanline_edge_pd_steering_defines.svh"

module sepd_scan
  import sepd_pkg::*;
#(
  parameter int IMAGE_WIDTH = 300
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  input  logic [PIX_W-1:0] in_pixel,
  input  logic             in_row_end,
  output logic             in_stall,
  output logic             res_valid,
  input  logic             res_ready,
  output row_res_t         res
);

  localparam int               CNT_W     = $clog2(IMAGE_WIDTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(IMAGE_WIDTH);
  localparam logic [COL_W-1:0] CENTER    = COL_W'(IMAGE_WIDTH / 2);
  localparam logic [COL_W-1:0] TRACK_RST = COL_W'(IMAGE_WIDTH / 2 + HALF_ROAD_RST);

  // input register
  logic             s1_v_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic             s1_end_r;

  // row state
  logic [CNT_W-1:0]        col_cnt_r, col_cnt_nxt;
  logic [PIX_W-1:0]        prev_pix_r, prev_pix_nxt;
  logic [COL_W-1:0]        track_r, track_nxt;
  logic signed [ERR_W-1:0] prev_err_r, prev_err_nxt;
  logic                    cand_found_r, cand_found_nxt;
  logic [COL_W-1:0]        cand_col_r, cand_col_nxt;
  logic [SPD_W-1:0]        row_cnt_r, row_cnt_nxt;

  // result register
  logic     res_v_r;
  row_res_t res_r, res_nxt;

  logic res_free;
  logic s1_go;
  logic accept;

  // handshake: plain pixels always drain, a row end needs a free result slot
  assign res_free = !res_v_r || res_ready;
  assign s1_go    = s1_v_r && (!s1_end_r || res_free);
  assign in_stall = s1_v_r && !s1_go;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r <= in_pixel;
      s1_end_r <= in_row_end;
    end
  end

  // neighbor step and window test
  logic [PIX_W-1:0]        diff;
  logic                    step_ok;
  logic signed [WIN_W-1:0] t_s, w_s, h_s, base_s, lo_s, hi_s, n_s, c_s;
  logic                    in_win;
  logic                    hit;
  logic                    take;
  logic                    found_now;
  logic [COL_W-1:0]        col_now;

  always_comb begin
    diff    = (s1_pix_r > prev_pix_r) ? (s1_pix_r - prev_pix_r) : (prev_pix_r - s1_pix_r);
    step_ok = (col_cnt_r != '0) && (col_cnt_r < CNT_MAX);

    t_s = $signed({{(WIN_W-COL_W){1'b0}}, track_r});
    w_s = $signed({{(WIN_W-SW_W){1'b0}}, cfg.win_width});
    h_s = w_s >>> 1;
    n_s = $signed({{(WIN_W-CNT_W){1'b0}}, col_cnt_r});

    // right side scans forward over [t-h+1, t-h+w-1], left side backward
    // over [t+h-w+1, t+h-1]; both share lo = base+1, hi = base+w-1
    base_s = cfg.lane_side ? (t_s - h_s) : (t_s + h_s - w_s);
    lo_s   = base_s + WIN_W'(1);
    hi_s   = base_s + w_s - WIN_W'(1);
    c_s    = cfg.lane_side ? n_s : (n_s - WIN_W'(1));
    in_win = (c_s >= lo_s) && (c_s <= hi_s);

    hit  = step_ok && (diff > cfg.edge_thresh) && in_win;
    // first edge in scan order: right keeps the first, left keeps the last
    take = hit && (!cfg.lane_side || !cand_found_r);

    found_now = cand_found_r || hit;
    col_now   = take ? c_s[COL_W-1:0] : cand_col_r;
  end

  // row-end values: new track, lane error, speed
  logic signed [ERR_W:0]   target_s;
  logic signed [ERR_W:0]   err_w;
  logic signed [ERR_W-1:0] err;
  logic signed [DERR_W-1:0] derr;
  logic [COL_W-1:0]        half_road;
  logic [COL_W-1:0]        track_new;
  logic [SPD_W-1:0]        speed;

  always_comb begin
    half_road = {{(COL_W-ROAD_W+1){1'b0}}, cfg.road_width[ROAD_W-1:1]};
    target_s  = cfg.lane_side
              ? ($signed({2'b00, CENTER}) + $signed({2'b00, half_road}))
              : ($signed({2'b00, CENTER}) - $signed({2'b00, half_road}));
    track_new = found_now ? col_now : track_r;
    err_w     = $signed({2'b00, track_new}) - target_s;
    err       = err_w[ERR_W-1:0];
    derr      = $signed({err[ERR_W-1], err}) - $signed({prev_err_r[ERR_W-1], prev_err_r});
    speed     = (row_cnt_r < cfg.speed_limit) ? row_cnt_r : cfg.speed_limit;
  end

  // state next values
  always_comb begin
    col_cnt_nxt    = col_cnt_r;
    prev_pix_nxt   = prev_pix_r;
    track_nxt      = track_r;
    prev_err_nxt   = prev_err_r;
    cand_found_nxt = cand_found_r;
    cand_col_nxt   = cand_col_r;
    row_cnt_nxt    = row_cnt_r;
    if (s1_go) begin
      if (s1_end_r) begin
        col_cnt_nxt    = '0;
        prev_pix_nxt   = '0;
        cand_found_nxt = 1'b0;
        cand_col_nxt   = '0;
        track_nxt      = track_new;
        if (found_now) begin
          prev_err_nxt = err;
        end
        if (row_cnt_r != ROW_CNT_MAX) begin
          row_cnt_nxt = row_cnt_r + SPD_W'(1);
        end
      end else begin
        prev_pix_nxt   = s1_pix_r;
        cand_found_nxt = found_now;
        cand_col_nxt   = col_now;
        if (col_cnt_r < CNT_MAX) begin
          col_cnt_nxt = col_cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r    <= '0;
      prev_pix_r   <= '0;
      track_r      <= TRACK_RST;
      prev_err_r   <= '0;
      cand_found_r <= 1'b0;
      cand_col_r   <= '0;
      row_cnt_r    <= ROW_CNT_RST;
    end else begin
      col_cnt_r    <= col_cnt_nxt;
      prev_pix_r   <= prev_pix_nxt;
      track_r      <= track_nxt;
      prev_err_r   <= prev_err_nxt;
      cand_found_r <= cand_found_nxt;
      cand_col_r   <= cand_col_nxt;
      row_cnt_r    <= row_cnt_nxt;
    end
  end

  // result beat
  always_comb begin
    res_nxt.found     = found_now;
    res_nxt.edge_col  = found_now ? col_now : '0;
    res_nxt.track_col = track_new;
    res_nxt.err       = err;
    res_nxt.derr      = derr;
    res_nxt.speed     = speed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (s1_go && s1_end_r) begin
      res_v_r <= 1'b1;
    end else if (res_ready) begin
      res_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_end_r) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_v_r;
  assign res       = res_r;

  // checks
  `SEPD_ASSERT(a_cnt_range, col_cnt_r <= CNT_MAX, "column count past image width")
  `SEPD_ASSERT_NEXT(a_row_clear, s1_go && s1_end_r, (col_cnt_r == '0) && !cand_found_r, "row state not cleared at row end")
  `SEPD_ASSERT(a_found_track, !(res_v_r && res_r.found) || (res_r.track_col == res_r.edge_col), "found edge not taken as tracked column")

endmodule

// File: rtl/sepd_pd.sv
// ----------------------------------------------------------------------------
// Scanline edge PD steering - PD steering stage
// Registered gain products, then sum, negate and saturate into the result
// register. The steering value is held on rows without an edge.
// ----------------------------------------------------------------------------
`include "scanline_edge_pd_steering_defines.svh"

module sepd_pd
  import sepd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      res_valid,
  output logic                      res_ready,
  input  row_res_t                  res,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_edge_found,
  output logic [COL_W-1:0]          out_edge_column,
  output logic [COL_W-1:0]          out_tracked_column,
  output logic signed [STEER_W-1:0] out_steer,
  output logic [SPD_W-1:0]          out_speed
);

  // product stage
  logic                     p_v_r;
  logic                     p_found_r;
  logic [COL_W-1:0]         p_col_r;
  logic [COL_W-1:0]         p_track_r;
  logic [SPD_W-1:0]         p_speed_r;
  logic signed [PROD_W-1:0] p_kp_r;
  logic signed [PROD_W-1:0] p_kd_r;

  // result register
  logic                      o_v_r;
  logic                      o_found_r;
  logic [COL_W-1:0]          o_col_r;
  logic [COL_W-1:0]          o_track_r;
  logic signed [STEER_W-1:0] o_steer_r, o_steer_nxt;
  logic [SPD_W-1:0]          o_speed_r;

  logic o_free;
  logic p_free;
  logic p_load;
  logic o_load;

  assign o_free    = !o_v_r || !out_stall;
  assign p_free    = !p_v_r || o_free;
  assign res_ready = p_free;
  assign p_load    = res_valid && p_free;
  assign o_load    = p_v_r && o_free;

  // gain products, gains zero-extended and errors sign-extended to the product width
  logic signed [PROD_W-1:0] kp_ext, kd_ext, err_ext, derr_ext;

  always_comb begin
    kp_ext   = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.kp_gain});
    kd_ext   = $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.kd_gain});
    err_ext  = $signed({{(PROD_W-ERR_W){res.err[ERR_W-1]}}, res.err});
    derr_ext = $signed({{(PROD_W-DERR_W){res.derr[DERR_W-1]}}, res.derr});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (p_load) begin
      p_v_r <= 1'b1;
    end else if (o_free) begin
      p_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_load) begin
      p_found_r <= res.found;
      p_col_r   <= res.edge_col;
      p_track_r <= res.track_col;
      p_speed_r <= res.speed;
      p_kp_r    <= kp_ext * err_ext;
      p_kd_r    <= kd_ext * derr_ext;
    end
  end

  // negated PD sum, saturated; held when the row had no edge
  logic signed [SUM_W-1:0] pd_sum;
  logic signed [SUM_W-1:0] pd_sat;

  always_comb begin
    pd_sum = -($signed({p_kp_r[PROD_W-1], p_kp_r}) + $signed({p_kd_r[PROD_W-1], p_kd_r}));
    if (pd_sum > STEER_MAX) begin
      pd_sat = STEER_MAX;
    end else if (pd_sum < STEER_MIN) begin
      pd_sat = STEER_MIN;
    end else begin
      pd_sat = pd_sum;
    end
    o_steer_nxt = p_found_r ? pd_sat[STEER_W-1:0] : o_steer_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_load) begin
      o_v_r <= 1'b1;
    end else if (!out_stall) begin
      o_v_r <= 1'b0;
    end
  end

  // the steer register doubles as the last steering value, so it resets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_steer_r <= '0;
    end else if (o_load) begin
      o_steer_r <= o_steer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_found_r <= p_found_r;
      o_col_r   <= p_col_r;
      o_track_r <= p_track_r;
      o_speed_r <= p_speed_r;
    end
  end

  assign out_valid          = o_v_r;
  assign out_edge_found     = o_found_r;
  assign out_edge_column    = o_col_r;
  assign out_tracked_column = o_track_r;
  assign out_steer          = o_steer_r;
  assign out_speed          = o_speed_r;

  // checks
  `SEPD_ASSERT(a_no_edge_col, !(o_v_r && !o_found_r) || (o_col_r == '0), "edge column set on a row without edge")
  `SEPD_ASSERT_NEXT(a_steer_hold, o_load && !p_found_r, $stable(o_steer_r), "steering changed on a row without edge")
  `SEPD_ASSERT_NEXT(a_out_hold, o_v_r && out_stall, o_v_r && $stable(o_track_r), "stalled beat changed")

endmodule

// File: rtl/scanline_edge_pd_steering.sv
// Throughput: one pixel per cycle while in_stall is low; each result
// passes the search stage, a gain product register and the saturating
// sum into the result register.
// Up to three row results may queue while the output is stalled.
// Reset: synchronous, active low; registers return to defaults and the
// tracked column to the image center plus half the default road width.
// ----------------------------------------------------------------------------
// Scanline edge PD steering - top level
// Finds the lane edge in a window of each grey scan row, tracks its column
// and gives a PD steering value and a ramped speed at every row end.
// ----------------------------------------------------------------------------
`include "scanline_edge_pd_steering_defines.svh"

module scanline_edge_pd_steering
  import sepd_pkg::*;
#(
  parameter int IMAGE_WIDTH = 300
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  // pixel stream
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [PIX_W-1:0]          in_pixel,
  input  logic                      in_row_end,
  // row results
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_edge_found,
  output logic [COL_W-1:0]          out_edge_column,
  output logic [COL_W-1:0]          out_tracked_column,
  output logic signed [STEER_W-1:0] out_steer,
  output logic [SPD_W-1:0]          out_speed
);

  // configuration registers
  cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.win_width   <= WIN_WIDTH_RST;
      cfg_r.edge_thresh <= EDGE_THR_RST;
      cfg_r.road_width  <= ROAD_WIDTH_RST;
      cfg_r.lane_side   <= LANE_SIDE_RST;
      cfg_r.kp_gain     <= KP_GAIN_RST;
      cfg_r.kd_gain     <= KD_GAIN_RST;
      cfg_r.speed_limit <= SPEED_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIN_WIDTH:   cfg_r.win_width   <= cfg_wdata[SW_W-1:0];
        REG_EDGE_THRESH: cfg_r.edge_thresh <= cfg_wdata[THR_W-1:0];
        REG_ROAD_WIDTH:  cfg_r.road_width  <= cfg_wdata[ROAD_W-1:0];
        REG_LANE_SIDE:   cfg_r.lane_side   <= cfg_wdata[0];
        REG_KP_GAIN:     cfg_r.kp_gain     <= cfg_wdata[GAIN_W-1:0];
        REG_KD_GAIN:     cfg_r.kd_gain     <= cfg_wdata[GAIN_W-1:0];
        REG_SPEED_LIMIT: cfg_r.speed_limit <= cfg_wdata[SPD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // scan stage -> steering stage
  logic     res_valid;
  logic     res_ready;
  row_res_t res;

  sepd_scan #(
    .IMAGE_WIDTH (IMAGE_WIDTH)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_pixel   (in_pixel),
    .in_row_end (in_row_end),
    .in_stall   (in_stall),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  sepd_pd u_pd (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .res_valid          (res_valid),
    .res_ready          (res_ready),
    .res                (res),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_edge_found     (out_edge_found),
    .out_edge_column    (out_edge_column),
    .out_tracked_column (out_tracked_column),
    .out_steer          (out_steer),
    .out_speed          (out_speed)
  );

endmodule

// File: sim/steer_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanline edge PD steering - row result scoreboard
// Keeps its own copy of the registers and the scan/steering state, predicts
// the result of every row end from the accepted pixels and checks the row
// results of the block in order.
// ----------------------------------------------------------------------------
package steer_scoreboard_pkg;
  import sepd_pkg::*;

  localparam int IMG_W = 300;

  typedef struct packed {
    logic                      edge_found;
    logic [COL_W-1:0]          edge_column;
    logic [COL_W-1:0]          tracked_column;
    logic signed [STEER_W-1:0] steer;
    logic [SPD_W-1:0]          speed;
  } row_result_t;

  class steer_scoreboard;
    cfg_t                      regs;
    logic [COL_W-1:0]          col_cnt;
    logic [PIX_W-1:0]          prev_pix;
    logic [COL_W-1:0]          track;
    logic signed [ERR_W-1:0]   prev_err;
    logic                      cand_found;
    logic [COL_W-1:0]          cand_col;
    logic signed [STEER_W-1:0] held_steer;
    logic [SPD_W-1:0]          row_cnt;
    row_result_t               rows_due[$];
    int                        mismatches;

    function new();
      regs.win_width   = WIN_WIDTH_RST;
      regs.edge_thresh = EDGE_THR_RST;
      regs.road_width  = ROAD_WIDTH_RST;
      regs.lane_side   = LANE_SIDE_RST;
      regs.kp_gain     = KP_GAIN_RST;
      regs.kd_gain     = KD_GAIN_RST;
      regs.speed_limit = SPEED_LIMIT_RST;
      col_cnt    = '0;
      prev_pix   = '0;
      track      = COL_W'(IMG_W / 2 + HALF_ROAD_RST);
      prev_err   = '0;
      cand_found = 1'b0;
      cand_col   = '0;
      held_steer = '0;
      row_cnt    = ROW_CNT_RST;
      mismatches = 0;
    endfunction

    // register write; unused indexes are dropped
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WIN_WIDTH:   regs.win_width   = data[SW_W-1:0];
        REG_EDGE_THRESH: regs.edge_thresh = data[THR_W-1:0];
        REG_ROAD_WIDTH:  regs.road_width  = data[ROAD_W-1:0];
        REG_LANE_SIDE:   regs.lane_side   = data[0];
        REG_KP_GAIN:     regs.kp_gain     = data[GAIN_W-1:0];
        REG_KD_GAIN:     regs.kd_gain     = data[GAIN_W-1:0];
        REG_SPEED_LIMIT: regs.speed_limit = data[SPD_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted pixel beat; a row end queues the predicted row result
    function void take_pixel(logic [PIX_W-1:0] pix, logic row_end);
      int          n, step, w, h, lo, hi, c, target, err, derr;
      longint      pd;
      row_result_t r;
      n = int'(col_cnt);
      // steps count only with both pixels inside the image
      if (n >= 1 && n < IMG_W) begin
        step = int'(pix) - int'(prev_pix);
        if (step < 0) step = -step;
        if (step > int'(regs.edge_thresh)) begin
          w = int'(regs.win_width);
          h = w / 2;
          if (regs.lane_side) begin
            // right line: left to right, the first step in the window stays
            c  = n;
            lo = int'(track) - h + 1;
            hi = int'(track) - h + w - 1;
            if (c >= lo && c <= hi && !cand_found) begin
              cand_found = 1'b1;
              cand_col   = COL_W'(c);
            end
          end else begin
            // left line: right to left, so the last step seen wins
            c  = n - 1;
            lo = int'(track) + h - w + 1;
            hi = int'(track) + h - 1;
            if (c >= lo && c <= hi) begin
              cand_found = 1'b1;
              cand_col   = COL_W'(c);
            end
          end
        end
      end
      prev_pix = pix;
      if (n < IMG_W) col_cnt = col_cnt + 1'b1;
      if (!row_end) return;

      // PD steering only moves when an edge was found
      if (cand_found) begin
        track  = cand_col;
        target = IMG_W / 2 + (regs.lane_side ? int'(regs.road_width) / 2
                                             : -(int'(regs.road_width) / 2));
        err      = int'(track) - target;
        derr     = err - int'(prev_err);
        prev_err = ERR_W'(err);
        pd = -(longint'(regs.kp_gain) * longint'(err) +
               longint'(regs.kd_gain) * longint'(derr));
        if (pd > STEER_MAX) pd = STEER_MAX;
        if (pd < STEER_MIN) pd = STEER_MIN;
        held_steer = STEER_W'(pd);
      end

      r.edge_found     = cand_found;
      r.edge_column    = cand_found ? cand_col : '0;
      r.tracked_column = track;
      r.steer          = held_steer;
      r.speed          = (row_cnt < regs.speed_limit) ? row_cnt : regs.speed_limit;
      rows_due.push_back(r);

      if (row_cnt != ROW_CNT_MAX) row_cnt = row_cnt + 1'b1;
      col_cnt    = '0;
      prev_pix   = '0;
      cand_found = 1'b0;
      cand_col   = '0;
    endfunction

    // one accepted result beat against the oldest predicted row
    function void check_row(row_result_t got);
      row_result_t want;
      if (rows_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected row result found=%0d edge=%0d track=%0d steer=%0d speed=%0d",
                   got.edge_found, got.edge_column, got.tracked_column, got.steer, got.speed);
        return;
      end
      want = rows_due.pop_front();
      if (got.edge_found !== want.edge_found || got.edge_column !== want.edge_column ||
          got.tracked_column !== want.tracked_column || got.steer !== want.steer ||
          got.speed !== want.speed) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: row result mismatch at %0t", $realtime);
          $display("  expected found=%0d edge=%0d track=%0d steer=%0d speed=%0d",
                   want.edge_found, want.edge_column, want.tracked_column, want.steer,
                   want.speed);
          $display("  actual   found=%0d edge=%0d track=%0d steer=%0d speed=%0d",
                   got.edge_found, got.edge_column, got.tracked_column, got.steer, got.speed);
        end
      end
    endfunction
  endclass

endpackage

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanline edge PD steering - testbench
// Streams grey scan rows with planted steps around the tracked column, pulls
// the track up and down, sweeps the registers between phases and checks
// every row result against the scoreboard, under random stalls.
// ----------------------------------------------------------------------------
module tb;
  import sepd_pkg::*;
  import steer_scoreboard_pkg::*;

  localparam int LAT_PAD     = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 360;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  logic [PIX_W-1:0]          in_pixel;
  logic                      in_row_end;
  logic                      out_valid;
  logic                      out_stall;
  logic                      out_edge_found;
  logic [COL_W-1:0]          out_edge_column;
  logic [COL_W-1:0]          out_tracked_column;
  logic signed [STEER_W-1:0] out_steer;
  logic [SPD_W-1:0]          out_speed;

  steer_scoreboard sb = new();
  bit in_gaps;
  bit out_gaps;
  bit hold_req;
  int px_sent;

  scanline_edge_pd_steering #(.IMAGE_WIDTH(IMG_W)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sample all three channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) sb.take_pixel(in_pixel, in_row_end);
      if (out_valid && !out_stall)
        sb.check_row(row_result_t'{out_edge_found, out_edge_column, out_tracked_column,
                                   out_steer, out_speed});
    end
  end

  // watchdog: ends the run after too long without any accepted beat
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL scanline_edge_pd_steering");
    $finish;
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin : result_side
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (out_gaps && $urandom_range(0, 99) < 6) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // one pixel beat; entered and left at a falling edge
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
    if (in_gaps && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel   <= pix;
    in_row_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    px_sent++;
  endtask

  // register write with random bits above the field width; valid left high
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val,
                           input int w);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= (CFG_DATA_W'($urandom) << w) | CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // wait until every predicted row is out and the pipeline has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.rows_due.size() != 0) @(posedge clk);
    repeat (LAT_PAD) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic int unsigned pick(int unsigned lo_v, int unsigned hi_v);
    case ($urandom_range(0, 5))
      0:       return lo_v;
      1:       return hi_v;
      default: return $urandom_range(lo_v, hi_v);
    endcase
  endfunction

  // random register settings, extremes included
  task automatic retune();
    if ($urandom_range(0, 1))
      cfg_write(REG_WIN_WIDTH, ($urandom_range(0, 3) == 0) ? pick(0, 127) : pick(2, 64), SW_W);
    if ($urandom_range(0, 1))
      cfg_write(REG_EDGE_THRESH, $urandom_range(0, 1) ? pick(0, 255) : pick(0, 60), THR_W);
    if ($urandom_range(0, 1)) cfg_write(REG_ROAD_WIDTH, pick(0, 255), ROAD_W);
    if ($urandom_range(0, 1)) cfg_write(REG_LANE_SIDE, $urandom_range(0, 1), 1);
    if ($urandom_range(0, 1)) cfg_write(REG_KP_GAIN, pick(0, 4095), GAIN_W);
    if ($urandom_range(0, 1)) cfg_write(REG_KD_GAIN, pick(0, 4095), GAIN_W);
    if ($urandom_range(0, 1)) cfg_write(REG_SPEED_LIMIT, pick(0, 255), SPD_W);
    if ($urandom_range(0, 7) == 0) cfg_write(REG_UNUSED, $urandom_range(0, 4095), CFG_DATA_W);
  endtask

  // one scan row: flat level with planted steps
  // aim 0 spreads steps near the window, 1 pulls the track down, 2 pulls it up,
  // 3 sends pure noise
  task automatic send_row(input int aim, input bit tiny);
    bit step_at[];
    int t, h, thr, len, level, mag, j, k, lo_j, hi_j;
    t   = int'(sb.track);
    h   = int'(sb.regs.win_width) / 2;
    thr = int'(sb.regs.edge_thresh);
    if (tiny) begin
      len = 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1:    len = $urandom_range(1, 40);
        7, 8:    len = IMG_W;
        9:       len = $urandom_range(IMG_W + 1, IMG_W + 20);
        default: len = t + h + $urandom_range(1, 20);
      endcase
      if (len > IMG_W + 20) len = IMG_W;
    end
    step_at = new[len];

    if (aim == 1 || aim == 2) begin
      j = (aim == 1) ? t - h + 2 : t + h - 1;
      if (j < 1) j = 1;
      if (j > IMG_W - 1) j = IMG_W - 1;
      if (j < len) step_at[j] = 1'b1;
    end else if (aim == 0) begin
      lo_j = (t - h - 2 < 0) ? 0 : t - h - 2;
      hi_j = (t + h + 2 > len - 1) ? len - 1 : t + h + 2;
      for (k = 0; k < $urandom_range(0, 3); k++) begin
        if (lo_j <= hi_j && $urandom_range(0, 9) < 6) j = $urandom_range(lo_j, hi_j);
        else j = $urandom_range(0, len - 1);
        step_at[j] = 1'b1;
      end
    end

    level = $urandom_range(0, 255);
    for (j = 0; j < len; j++) begin
      if (aim == 3) begin
        level = $urandom_range(0, 255);
      end else if (step_at[j]) begin
        case ($urandom_range(0, 3))
          0:       mag = thr;  // exactly the threshold: no edge
          1:       mag = thr + 1;
          default: mag = $urandom_range((thr + 1 > 255) ? 255 : thr + 1, 255);
        endcase
        if (level + mag <= 255) level = level + mag;
        else if (level - mag >= 0) level = level - mag;
        else level = (level < 128) ? 255 : 0;
      end
      send_pixel(PIX_W'(level), j == len - 1);
    end
  endtask

  initial begin : stimulus
    int ph, r, mode, aim;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_pixel   = '0;
    in_row_end = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_gaps    = 1'b0;
    out_gaps   = 1'b0;
    hold_req   = 1'b0;
    px_sent    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single-pixel rows at both pixel extremes
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b1);
    // full-scale steps in a short row, far from the window
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'h55, 1'b1);
    // step equal to the default threshold
    send_pixel(8'd100, 1'b0);
    send_pixel(8'd150, 1'b0);
    send_pixel(8'd99, 1'b1);
    drain();

    // every register at one extreme, plus a write to an unused index
    cfg_write(REG_WIN_WIDTH, 0, SW_W);
    cfg_write(REG_EDGE_THRESH, 0, THR_W);
    cfg_write(REG_ROAD_WIDTH, 255, ROAD_W);
    cfg_write(REG_LANE_SIDE, 0, 1);
    cfg_write(REG_KP_GAIN, 4095, GAIN_W);
    cfg_write(REG_KD_GAIN, 4095, GAIN_W);
    cfg_write(REG_SPEED_LIMIT, 0, SPD_W);
    cfg_write(REG_UNUSED, 12'hFFF, CFG_DATA_W);
    cfg_valid <= 1'b0;
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b1);
    drain();

    // and at the other extreme
    cfg_write(REG_WIN_WIDTH, 127, SW_W);
    cfg_write(REG_EDGE_THRESH, 255, THR_W);
    cfg_write(REG_ROAD_WIDTH, 0, ROAD_W);
    cfg_write(REG_LANE_SIDE, 1, 1);
    cfg_write(REG_KP_GAIN, 0, GAIN_W);
    cfg_write(REG_KD_GAIN, 0, GAIN_W);
    cfg_write(REG_SPEED_LIMIT, 255, SPD_W);
    cfg_valid <= 1'b0;
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h01, 1'b1);

    // random phases, new register settings between them
    for (ph = 0; px_sent < PHASE_ITEMS; ph++) begin
      drain();
      retune();
      if (ph == 1) cfg_write(REG_SPEED_LIMIT, 255, SPD_W);
      cfg_valid <= 1'b0;
      in_gaps  = ($urandom_range(0, 3) != 0);
      out_gaps = ($urandom_range(0, 3) != 0);
      if (ph == 1) begin
        // long result hold while tiny rows keep coming; also saturates the row count
        in_gaps  = 1'b0;
        hold_req = 1'b1;
        for (r = 0; r < 250; r++) send_row(0, 1'b1);
      end else begin
        mode = $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) aim = 3;
        else if (mode == 0 || $urandom_range(0, 3) == 0) aim = 0;
        else aim = mode;
        send_row(aim, 1'b0);
      end
    end

    // closing stretch without any idling
    drain();
    retune();
    cfg_valid <= 1'b0;
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    send_row(0, 1'b0);
    drain();

    if (sb.mismatches == 0 && sb.rows_due.size() == 0)
      $display("PASS scanline_edge_pd_steering");
    else
      $display("FAIL scanline_edge_pd_steering");
    $finish;
  end

endmodule
